// File: design/usvd_pkg.sv
// ----------------------------------------------------------------------------
// usvd_pkg
// Shared types, field widths and helpers of the UTF-8 stream validating
// decoder.
// ----------------------------------------------------------------------------
package usvd_pkg;

    localparam int CP_W        = 21;
    localparam int LEN_W       = 3;
    localparam int OUT_COUNT_W = 32;

    localparam logic [7:0] LEAD2_MASK = 8'h1F;
    localparam logic [7:0] LEAD3_MASK = 8'h0F;
    localparam logic [7:0] LEAD4_MASK = 8'h07;
    localparam logic [7:0] CONT_MASK  = 8'h3F;
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] CONT_MIN   = 8'h80;
    localparam logic [7:0] CONT_MAX   = 8'hBF;
    localparam logic [CP_W-1:0] LATIN_MAX  = 21'h0000FF;
    localparam logic [7:0]      UNDERSCORE = 8'h5F;

    typedef logic [CP_W-1:0]  t_code_point;
    typedef logic [LEN_W-1:0] t_seq_len;

    typedef enum logic [1:0] {
        CLASS_CONTROL = 2'd0,
        CLASS_PUNCT   = 2'd1,
        CLASS_WORD    = 2'd2,
        CLASS_OTHER   = 2'd3
    } t_char_class;

    typedef struct packed {
        t_code_point code_point;
        t_seq_len    seq_length;
        logic        well_formed;
        logic        is_terminator;
        logic        end_of_string;
    } t_decoded;

    typedef struct packed {
        t_decoded                 dec;
        t_char_class              char_class;
        logic [OUT_COUNT_W-1:0]   point_count;
    } t_result;

    function automatic t_char_class classify(input t_code_point cp);
        logic [7:0]  c;
        t_char_class cls;
        c = cp[7:0];
        if (cp > LATIN_MAX) begin
            cls = CLASS_OTHER;
        end else if (c <= 8'h20 || c == ASCII_MAX) begin
            cls = CLASS_CONTROL;
        end else if (c >= CONT_MIN) begin
            cls = CLASS_PUNCT;
        end else if (c == UNDERSCORE || (c >= 8'h30 && c <= 8'h39) ||
                     (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
            cls = CLASS_WORD;
        end else begin
            cls = CLASS_PUNCT;
        end
        return cls;
    endfunction

endpackage

// File: design/usvd_fifo.sv
// ----------------------------------------------------------------------------
// usvd_fifo
// Small register queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module usvd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT) else $error("queue count out of range");

endmodule

// File: design/usvd_front.sv
// ----------------------------------------------------------------------------
// usvd_front
// Byte intake: assembles multi-byte sequences, checks the continuation byte
// range and hands one decoded record per code point to the middle queue.
// ----------------------------------------------------------------------------
module usvd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data,
    input  logic              i_q_full,
    output logic              o_q_push,
    output usvd_pkg::t_decoded o_q_data
);
    import usvd_pkg::*;

    logic        r_nul_terminates;
    logic [1:0]  r_pending, n_pending;
    t_seq_len    r_total, n_total;
    t_code_point r_acc, n_acc;
    logic        r_ok, n_ok;

    logic        w_accept;

    function automatic t_code_point fill_shift(input t_code_point v, input logic [1:0] p);
        t_code_point r;
        case (p)
            2'd0:    r = v;
            2'd1:    r = {v[CP_W-7:0], 6'd0};
            2'd2:    r = {v[CP_W-13:0], 12'd0};
            2'd3:    r = {v[CP_W-19:0], 18'd0};
            default: r = v;
        endcase
        return r;
    endfunction

    assign full        = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = push && !i_q_full;

    always_comb begin
        logic [1:0]  lead_p;
        t_seq_len    lead_total;
        t_code_point lead_acc;
        logic        is_lead;
        t_code_point acc_c;
        logic        ok_c;
        logic [1:0]  pend_c;

        n_pending = r_pending;
        n_total   = r_total;
        n_acc     = r_acc;
        n_ok      = r_ok;
        o_q_push  = 1'b0;
        o_q_data  = '0;
        lead_p     = 2'd0;
        lead_total = '0;
        lead_acc   = '0;
        is_lead    = 1'b0;
        acc_c      = {r_acc[CP_W-7:0], i_data_byte[5:0] & CONT_MASK[5:0]};
        ok_c       = r_ok && (i_data_byte >= CONT_MIN) && (i_data_byte <= CONT_MAX);
        pend_c     = r_pending - 1'b1;

        if (w_accept) begin
            if (r_pending == 2'd0) begin
                if (i_data_byte == 8'h00 && r_nul_terminates) begin
                    o_q_push               = 1'b1;
                    o_q_data.seq_length    = 3'd1;
                    o_q_data.well_formed   = 1'b1;
                    o_q_data.is_terminator = 1'b1;
                    o_q_data.end_of_string = 1'b1;
                end else if (i_data_byte <= ASCII_MAX) begin
                    o_q_push               = 1'b1;
                    o_q_data.code_point    = CP_W'(i_data_byte);
                    o_q_data.seq_length    = 3'd1;
                    o_q_data.well_formed   = 1'b1;
                    o_q_data.end_of_string = i_last_byte;
                end else if (i_data_byte[7:5] == 3'b110) begin
                    is_lead    = 1'b1;
                    lead_p     = 2'd1;
                    lead_total = 3'd2;
                    lead_acc   = CP_W'(i_data_byte & LEAD2_MASK);
                end else if (i_data_byte[7:4] == 4'b1110) begin
                    is_lead    = 1'b1;
                    lead_p     = 2'd2;
                    lead_total = 3'd3;
                    lead_acc   = CP_W'(i_data_byte & LEAD3_MASK);
                end else if (i_data_byte[7:3] == 5'b11110) begin
                    is_lead    = 1'b1;
                    lead_p     = 2'd3;
                    lead_total = 3'd4;
                    lead_acc   = CP_W'(i_data_byte & LEAD4_MASK);
                end else begin
                    o_q_push               = 1'b1;
                    o_q_data.code_point    = CP_W'(i_data_byte);
                    o_q_data.seq_length    = 3'd1;
                    o_q_data.end_of_string = i_last_byte;
                end
                if (is_lead) begin
                    if (i_last_byte) begin
                        o_q_push               = 1'b1;
                        o_q_data.code_point    = fill_shift(lead_acc, lead_p);
                        o_q_data.seq_length    = 3'd1;
                        o_q_data.end_of_string = 1'b1;
                    end else begin
                        n_pending = lead_p;
                        n_total   = lead_total;
                        n_acc     = lead_acc;
                        n_ok      = 1'b1;
                    end
                end
            end else begin
                if (pend_c == 2'd0) begin
                    o_q_push               = 1'b1;
                    o_q_data.code_point    = acc_c;
                    o_q_data.seq_length    = r_total;
                    o_q_data.well_formed   = ok_c;
                    o_q_data.end_of_string = i_last_byte;
                end else if (i_last_byte) begin
                    o_q_push               = 1'b1;
                    o_q_data.code_point    = fill_shift(acc_c, pend_c);
                    o_q_data.seq_length    = r_total - {1'b0, pend_c};
                    o_q_data.end_of_string = 1'b1;
                end else begin
                    n_pending = pend_c;
                    n_acc     = acc_c;
                    n_ok      = ok_c;
                end
            end
            if (o_q_push) begin
                n_pending = 2'd0;
                n_total   = '0;
                n_acc     = '0;
                n_ok      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nul_terminates <= 1'b1;
            r_pending        <= 2'd0;
            r_total          <= '0;
            r_acc            <= '0;
            r_ok             <= 1'b1;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_nul_terminates <= i_cfg_data;
            end
            r_pending <= n_pending;
            r_total   <= n_total;
            r_acc     <= n_acc;
            r_ok      <= n_ok;
        end
    end

    a_idle_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 2'd0 |-> r_total == '0) else $error("stale sequence length");

    a_pending_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd0 |-> r_total == {1'b0, r_pending} + 3'd1 || r_total > {1'b0, r_pending})
        else $error("pending bytes exceed sequence length");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_full |-> !o_q_push) else $error("record pushed into full queue");

endmodule

// File: design/usvd_back.sv
// ----------------------------------------------------------------------------
// usvd_back
// Result stage: classifies each decoded code point and tracks the
// saturating code point count of the current string.
// ----------------------------------------------------------------------------
module usvd_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  usvd_pkg::t_decoded i_q_data,
    output logic               o_q_pop,
    input  logic               i_r_full,
    output logic               o_r_push,
    output usvd_pkg::t_result  o_r_data
);
    import usvd_pkg::*;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [COUNT_WIDTH-1:0] w_inc;
    logic                   w_move;

    assign w_move   = !i_q_empty && !i_r_full;
    assign o_q_pop  = w_move;
    assign o_r_push = w_move;
    assign w_inc    = (r_count == '1) ? r_count : r_count + 1'b1;

    always_comb begin
        o_r_data            = '0;
        o_r_data.dec        = i_q_data;
        o_r_data.char_class = classify(i_q_data.code_point);
        if (i_q_data.is_terminator) begin
            o_r_data.point_count = OUT_COUNT_W'(r_count);
        end else begin
            o_r_data.point_count = OUT_COUNT_W'(w_inc);
        end
        n_count = r_count;
        if (w_move) begin
            n_count = i_q_data.end_of_string ? '0 : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move && i_q_data.end_of_string |=> r_count == '0)
        else $error("count did not restart at end of string");

endmodule

// File: design/utf8_stream_validate_decode.sv
// ----------------------------------------------------------------------------
// utf8_stream_validate_decode
// UTF-8 stream decoder with range validation, character class and count.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while full is low and delivers one result per
// cycle while results are popped, for every completed code point. At the
// accepting edge the intake writes a decoded record into a two-entry queue.
// The result stage then moves it into a two-entry output queue and adds the
// class and count; the output ports show the oldest entry of that queue.
// Bytes that only extend a sequence give no result. While results are not
// popped, the output queue fills and then the middle queue fills. Full
// rises once four results are waiting, and the intake then holds every
// byte. The configuration write channel is always ready.
module utf8_stream_validate_decode #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_seq_length,
    output logic [1:0]  o_char_class,
    output logic        o_well_formed,
    output logic        o_is_terminator,
    output logic [31:0] o_point_count,
    output logic        o_end_of_string
);
    import usvd_pkg::*;

    localparam int DEC_W = $bits(t_decoded);
    localparam int RES_W = $bits(t_result);

    t_decoded w_front_data, w_mid_data;
    t_result  w_back_data, w_out_data;
    logic     w_front_push, w_mid_full, w_mid_empty, w_mid_pop;
    logic     w_back_push, w_out_full;

    usvd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (w_mid_full),
        .o_q_push    (w_front_push),
        .o_q_data    (w_front_data)
    );

    usvd_fifo #(.WIDTH(DEC_W), .DEPTH(2)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_wdata (w_front_data),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_empty (w_mid_empty),
        .o_rdata (w_mid_data)
    );

    usvd_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_mid_empty),
        .i_q_data  (w_mid_data),
        .o_q_pop   (w_mid_pop),
        .i_r_full  (w_out_full),
        .o_r_push  (w_back_push),
        .o_r_data  (w_back_data)
    );

    usvd_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_back_push),
        .i_wdata (w_back_data),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (w_out_data)
    );

    assign o_code_point    = w_out_data.dec.code_point;
    assign o_seq_length    = w_out_data.dec.seq_length;
    assign o_char_class    = w_out_data.char_class;
    assign o_well_formed   = w_out_data.dec.well_formed;
    assign o_is_terminator = w_out_data.dec.is_terminator;
    assign o_point_count   = w_out_data.point_count;
    assign o_end_of_string = w_out_data.dec.end_of_string;

endmodule

// File: bench/utf8_stream_validate_decode_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_validate_decode_tb
// Self-checking bench for the UTF-8 stream validating decoder.
// ----------------------------------------------------------------------------
// A queue-fed driver pushes bytes. Each accepted byte runs through a local
// decoder that tracks the sequence, the string count and the NUL mode, and
// stores the code point that it expects. A monitor pops results under random
// stalls and compares every field with the oldest stored code point. Short
// directed strings come first, then random text made mostly of well-formed
// sequences, under both settings of the NUL mode.
// ----------------------------------------------------------------------------
module utf8_stream_validate_decode_tb;
    import usvd_pkg::*;

    typedef struct {
        logic [20:0] code_point;
        logic [2:0]  seq_length;
        t_char_class char_class;
        logic        well_formed;
        logic        is_terminator;
        logic [31:0] point_count;
        logic        end_of_string;
    } t_point_due;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        push            = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte     = 8'h00;
    logic        i_last_byte     = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data      = 1'b0;
    logic        empty;
    logic        pop             = 1'b0;
    logic [20:0] o_code_point;
    logic [2:0]  o_seq_length;
    logic [1:0]  o_char_class;
    logic        o_well_formed;
    logic        o_is_terminator;
    logic [31:0] o_point_count;
    logic        o_end_of_string;

    // decoder state
    logic        nul_ends_string = 1'b1;
    logic [1:0]  lead_left       = 2'd0;
    logic [2:0]  seq_bytes       = 3'd0;
    logic [20:0] cp_accum        = 21'd0;
    logic        seq_valid       = 1'b1;
    logic [31:0] point_total     = 32'd0;

    logic [8:0]  byte_queue[$];
    t_point_due  points_due[$];
    int          bytes_taken     = 0;
    int          mismatch_count  = 0;
    int          tx_gap          = 0;
    int          rx_gap          = 0;
    logic        rx_hold         = 1'b0;
    logic        calm            = 1'b0;

    utf8_stream_validate_decode u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .empty           (empty),
        .pop             (pop),
        .o_code_point    (o_code_point),
        .o_seq_length    (o_seq_length),
        .o_char_class    (o_char_class),
        .o_well_formed   (o_well_formed),
        .o_is_terminator (o_is_terminator),
        .o_point_count   (o_point_count),
        .o_end_of_string (o_end_of_string)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_char_class class_of(input logic [20:0] cp);
        t_char_class cls;
        if (cp <= 21'h20 || cp == 21'h7F) begin
            cls = CLASS_CONTROL;
        end else if ((cp >= 21'h21 && cp <= 21'h2F) || (cp >= 21'h3A && cp <= 21'h40) ||
                     (cp >= 21'h5B && cp <= 21'h5E) || cp == 21'h60 ||
                     (cp >= 21'h7B && cp <= 21'h7E) || (cp >= 21'h80 && cp <= 21'hFF)) begin
            cls = CLASS_PUNCT;
        end else if (cp == 21'h5F || (cp >= 21'h30 && cp <= 21'h39) ||
                     (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A)) begin
            cls = CLASS_WORD;
        end else begin
            cls = CLASS_OTHER;
        end
        return cls;
    endfunction

    task automatic clear_sequence();
        lead_left = 2'd0;
        seq_bytes = 3'd0;
        cp_accum  = 21'd0;
        seq_valid = 1'b1;
    endtask

    task automatic emit_point(input logic [20:0] cp, input logic [2:0] len,
                              input logic ok, input logic last);
        t_point_due pt;
        if (point_total != 32'hFFFF_FFFF) point_total++;
        pt.code_point    = cp;
        pt.seq_length    = len;
        pt.char_class    = class_of(cp);
        pt.well_formed   = ok;
        pt.is_terminator = 1'b0;
        pt.point_count   = point_total;
        pt.end_of_string = last;
        points_due.push_back(pt);
        clear_sequence();
        if (last) point_total = 32'd0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        t_point_due pt;
        if (lead_left == 2'd0) begin
            if (b == 8'h00 && nul_ends_string) begin
                pt.code_point    = 21'd0;
                pt.seq_length    = 3'd1;
                pt.char_class    = CLASS_CONTROL;
                pt.well_formed   = 1'b1;
                pt.is_terminator = 1'b1;
                pt.point_count   = point_total;
                pt.end_of_string = 1'b1;
                points_due.push_back(pt);
                clear_sequence();
                point_total = 32'd0;
                return;
            end
            if (b <= 8'h7F) begin
                emit_point({13'd0, b}, 3'd1, 1'b1, last);
                return;
            end
            if (b >= 8'hC0 && b <= 8'hDF) begin
                lead_left = 2'd1;
                seq_bytes = 3'd2;
                cp_accum  = {16'd0, b[4:0]};
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                lead_left = 2'd2;
                seq_bytes = 3'd3;
                cp_accum  = {17'd0, b[3:0]};
            end else if (b >= 8'hF0 && b <= 8'hF7) begin
                lead_left = 2'd3;
                seq_bytes = 3'd4;
                cp_accum  = {18'd0, b[2:0]};
            end else begin
                emit_point({13'd0, b}, 3'd1, 1'b0, last);
                return;
            end
            seq_valid = 1'b1;
        end else begin
            cp_accum = {cp_accum[14:0], b[5:0]};
            if (b < 8'h80 || b > 8'hBF) seq_valid = 1'b0;
            lead_left = lead_left - 2'd1;
            if (lead_left == 2'd0) begin
                emit_point(cp_accum, seq_bytes, seq_valid, last);
                return;
            end
        end
        if (last) begin
            emit_point(cp_accum << (lead_left * 6), seq_bytes - {1'b0, lead_left}, 1'b0, 1'b1);
        end
    endtask

    task automatic flag_error(input string msg);
        $display("[%0t] %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s mismatch: got 0x%0h, want 0x%0h", name, got, want));
        end
    endtask

    // sender: hold the byte until its transfer, then advance
    always @(posedge i_clk) begin : drive_bytes
        logic [8:0] item;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                decode_byte(i_data_byte, i_last_byte);
                bytes_taken++;
            end
            if (!push || !full) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    push <= 1'b0;
                end else if (byte_queue.size() == 0) begin
                    push <= 1'b0;
                end else if (!calm && $urandom_range(0, 15) == 0) begin
                    tx_gap = $urandom_range(0, 18);
                    push <= 1'b0;
                end else begin
                    item = byte_queue.pop_front();
                    push        <= 1'b1;
                    i_data_byte <= item[7:0];
                    i_last_byte <= item[8];
                end
            end
        end
    end

    // receiver: compare each transfer with the oldest code point due
    always @(posedge i_clk) begin : take_results
        t_point_due pt;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (points_due.size() == 0) begin
                    flag_error($sformatf("unexpected result, code_point 0x%0h", o_code_point));
                end else begin
                    pt = points_due.pop_front();
                    check_field("code_point", 32'(o_code_point), 32'(pt.code_point));
                    check_field("seq_length", 32'(o_seq_length), 32'(pt.seq_length));
                    check_field("char_class", 32'(o_char_class), 32'(pt.char_class));
                    check_field("well_formed", 32'(o_well_formed), 32'(pt.well_formed));
                    check_field("is_terminator", 32'(o_is_terminator),
                                32'(pt.is_terminator));
                    check_field("point_count", o_point_count, pt.point_count);
                    check_field("end_of_string", 32'(o_end_of_string),
                                32'(pt.end_of_string));
                end
            end
            if (rx_hold) begin
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                rx_gap = $urandom_range(0, 18);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // hold off the receiver long enough to back the input up
    initial begin : long_stall
        while (bytes_taken < 350) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin : watchdog
        #(400_000 * 10);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic add_byte(input logic [7:0] b, input logic last = 1'b0);
        byte_queue.push_back({last, b});
    endtask

    function automatic logic [7:0] random_lead(input int len);
        logic [7:0] lead;
        case (len)
            1:       lead = 8'($urandom_range(8'h00, 8'h7F));
            2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
            3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF7));
        endcase
        return lead;
    endfunction

    task automatic add_random_text(input int n);
        int start;
        int kind;
        int len;
        int k;
        start = byte_queue.size();
        while (byte_queue.size() - start < n) begin
            kind = $urandom_range(0, 19);
            len  = $urandom_range(1, 4);
            if (kind < 13) begin
                add_byte(random_lead(len), $urandom_range(0, 29) == 0);
                for (k = 1; k < len; k++) begin
                    add_byte(8'($urandom_range(8'h80, 8'hBF)), $urandom_range(0, 29) == 0);
                end
            end else if (kind == 13) begin
                add_byte(8'h00, $urandom_range(0, 3) == 0);
            end else if (kind < 17) begin
                // cut short or corrupted sequence
                add_byte(random_lead($urandom_range(2, 4)));
                for (k = 1; k < len; k++) begin
                    add_byte(8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                          : $urandom_range(8'h80, 8'hBF)));
                end
            end else begin
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
            end
        end
    endtask

    task automatic drain();
        while (byte_queue.size() != 0 || push) @(posedge i_clk);
        while (points_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_nul_mode(input logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        nul_ends_string = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_nul_mode(1'b1);

        add_byte(8'h41); add_byte(8'h5F); add_byte(8'h7F); add_byte(8'h20);
        add_byte(8'h00);
        add_byte(8'hC3); add_byte(8'hA9);
        add_byte(8'hE2); add_byte(8'h82); add_byte(8'hAC);
        add_byte(8'hF0); add_byte(8'h9F); add_byte(8'h98); add_byte(8'h80);
        add_byte(8'hF4); add_byte(8'h8F); add_byte(8'hBF); add_byte(8'hBF);
        add_byte(8'h80); add_byte(8'hFF); add_byte(8'hF8);
        add_byte(8'hC3); add_byte(8'h00);
        add_byte(8'hE2); add_byte(8'h41); add_byte(8'h82);
        add_byte(8'h7E, 1'b1);
        add_byte(8'hE2); add_byte(8'h82, 1'b1);
        add_byte(8'hF0, 1'b1);
        drain();

        write_nul_mode(1'b0);
        add_byte(8'h00); add_byte(8'h61); add_byte(8'h00, 1'b1);
        drain();

        write_nul_mode(1'b1);
        add_random_text(260);
        drain();

        write_nul_mode(1'b0);
        add_random_text(260);
        drain();

        write_nul_mode(1'b1);
        calm <= 1'b1;
        add_random_text(250);
        drain();

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/usvd_pkg.sv
design/usvd_fifo.sv
design/usvd_front.sv
design/usvd_back.sv
design/utf8_stream_validate_decode.sv
bench/utf8_stream_validate_decode_tb.sv
